FILE: design/vogel_disk_point_generator_macros.svh
// Assertion macros used by the checker file.
`ifndef VOGEL_DISK_POINT_GENERATOR_MACROS_SVH
`define VOGEL_DISK_POINT_GENERATOR_MACROS_SVH
// Check a property on the rising clock edge, disabled while in reset.
`define VDPG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds on the rising clock edge, outside reset.
`define VDPG_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

FILE: design/vdpg_pkg.sv
// Package: widths, constants and CORDIC table for the disk point generator.
`default_nettype none
package vdpg_pkg;
    localparam int MaxPoints = 256;
    localparam int AngleFracBits = 16;
    localparam int CordicSteps = 20;
    localparam int DivSteps = 32;
    localparam int SqrtSteps = 16;
    localparam logic [31:0] GoldenTurn32 = 32'd1640531527;
    localparam logic [31:0] GoldenRounded =
        32'((64'(GoldenTurn32) + (64'd1 << (31 - AngleFracBits))) >> (32 - AngleFracBits));
    localparam logic [29:0] CordicGain = 30'd652032874;
    localparam logic signed [16:0] XyLimit = 17'sd65535;
    localparam logic [1:0] CfgPointCount = 2'd0;
    localparam logic [1:0] CfgDiskRadius = 2'd1;

    typedef logic signed [47:0] cw_t;

    function automatic logic [31:0] atan_turn(input int k);
        logic [31:0] a;
        case (k)
            0: a = 32'h20000000;  1: a = 32'h12E4051E;  2: a = 32'h09FB385B;
            3: a = 32'h051111D4;  4: a = 32'h028B0D43;  5: a = 32'h0145D7E1;
            6: a = 32'h00A2F61E;  7: a = 32'h00517C55;  8: a = 32'h0028BE53;
            9: a = 32'h00145F2F; 10: a = 32'h000A2F98; 11: a = 32'h000517CC;
            12: a = 32'h00028BE6; 13: a = 32'h000145F3; 14: a = 32'h0000A2F9;
            15: a = 32'h0000517D; 16: a = 32'h000028BE; 17: a = 32'h0000145F;
            18: a = 32'h00000A30; 19: a = 32'h00000518;
            default: a = 32'h0;
        endcase
        return a;
    endfunction
endpackage
`default_nettype wire

FILE: design/vogel_disk_point_generator.sv
// Top level: configuration registers, output register and datapath.
// Throughput: one item per cycle; set by the fully pipelined divider,
// square root and 20-stage CORDIC, which move only when the output can take.
// Reset clears valid bits and loads point_count 16 and disk_radius 256.
`default_nettype none
module vogel_disk_point_generator
    import vdpg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         point_index,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [16:0]      point_x,
    output logic signed [16:0]      point_y,
    output logic                    point_valid
);
    logic [8:0]  cnt_reg;
    logic [15:0] rad_reg;
    logic        ovld_reg;
    logic        en;
    logic        p_vld, p_ok;
    logic signed [16:0] p_x, p_y;
    logic signed [16:0] x_reg, y_reg;
    logic        ok_reg;

    // hold config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 9'd16;
            rad_reg <= 16'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CfgPointCount: cnt_reg <= cfg_data[8:0];
                CfgDiskRadius: rad_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // advance the pipe whenever the output register is free or draining
    assign en = !ovld_reg || out_ready;
    assign in_ready = en;

    vdpg_pipe u_pipe (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_valid),
        .idx(point_index), .cnt(cnt_reg), .radius(rad_reg),
        .out_vld(p_vld), .out_x(p_x), .out_y(p_y), .out_ok(p_ok)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovld_reg <= 1'b0;
        else if (en)
            ovld_reg <= p_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= p_x;
            y_reg <= p_y;
            ok_reg <= p_ok;
        end
    end

    assign out_valid = ovld_reg;
    assign point_x = x_reg;
    assign point_y = y_reg;
    assign point_valid = ok_reg;
endmodule
`default_nettype wire

FILE: design/vdpg_pipe.sv
// Pipelined datapath: divider, square root, scaling, CORDIC and quadrant fix.
`default_nettype none
module vdpg_pipe
    import vdpg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_vld,
    input  wire logic [7:0]         idx,
    input  wire logic [8:0]         cnt,
    input  wire logic [15:0]        radius,
    output logic                    out_vld,
    output logic signed [16:0]      out_x,
    output logic signed [16:0]      out_y,
    output logic                    out_ok
);
    // item context carried along the pipe
    typedef struct packed {
        logic        ok;
        logic        single;
        logic [1:0]  quad;
        logic [29:0] zph;
        logic [15:0] radius;
    } ctx_t;

    // register stages: divider 33, sqrt 17, scaling 2, CORDIC 21, output 1
    localparam int NS = DivSteps + SqrtSteps + CordicSteps + 5;

    logic [NS:0] v_reg;

    // restoring divider stages
    logic [31:0] dq_reg  [DivSteps+1];
    logic [9:0]  dr_reg  [DivSteps+1];
    logic [9:0]  dd_reg  [DivSteps+1];
    ctx_t        dc_reg  [DivSteps+1];
    // sqrt stages
    logic [31:0] sv_reg  [SqrtSteps+1];
    logic [17:0] sr_reg  [SqrtSteps+1];
    logic [15:0] sq_reg  [SqrtSteps+1];
    ctx_t        sc_reg  [SqrtSteps+1];
    logic [31:0] rm_reg;
    ctx_t        rc_reg;
    logic [47:0] xm_reg;
    ctx_t        xc_reg;
    cw_t         cx_reg  [CordicSteps+1];
    cw_t         cy_reg  [CordicSteps+1];
    logic signed [32:0] cz_reg [CordicSteps+1];
    ctx_t        cc_reg  [CordicSteps+1];
    logic signed [16:0] ox_reg, oy_reg;
    logic               ok_reg;

    logic [7:0]  ci;
    logic [8:0]  cn;
    logic [31:0] ang;
    ctx_t        c0;
    always_comb
    begin
        cn = (cnt > 9'(MaxPoints)) ? 9'(MaxPoints) : cnt;
        ang = (32'(idx) * GoldenRounded) & ((32'd1 << AngleFracBits) - 32'd1);
        ang = ang << (32 - AngleFracBits);
        ci = idx;
        c0.ok = (cn != 9'd0) && ({1'b0, ci} < cn);
        c0.single = (cn == 9'd1);
        c0.quad = ang[31:30];
        c0.zph = ang[29:0];
        c0.radius = radius;
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NS-1:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // load divider: dividend (2i+1)<<32 over 2C, one quotient bit a stage
            dq_reg[0] <= '0;
            dr_reg[0] <= 10'({1'b0, ci, 1'b1});
            dd_reg[0] <= {cn, 1'b0};
            dc_reg[0] <= c0;
            for (int k = 0; k < DivSteps; k++)
            begin
                logic [10:0] t;
                t = {dr_reg[k], 1'b0};
                if (t >= {1'b0, dd_reg[k]} && dd_reg[k] != 10'd0)
                begin
                    dr_reg[k+1] <= 10'(t - {1'b0, dd_reg[k]});
                    dq_reg[k+1] <= {dq_reg[k][30:0], 1'b1};
                end
                else
                begin
                    dr_reg[k+1] <= t[9:0];
                    dq_reg[k+1] <= {dq_reg[k][30:0], 1'b0};
                end
                dd_reg[k+1] <= dd_reg[k];
                dc_reg[k+1] <= dc_reg[k];
            end
            // sqrt: one result bit a stage
            sv_reg[0] <= dq_reg[DivSteps];
            sr_reg[0] <= '0;
            sq_reg[0] <= '0;
            sc_reg[0] <= dc_reg[DivSteps];
            for (int k = 0; k < SqrtSteps; k++)
            begin
                logic [17:0] rem;
                logic [17:0] trial;
                rem = {sr_reg[k][15:0], sv_reg[k][31:30]};
                trial = {sq_reg[k], 2'b01};
                if (rem >= trial)
                begin
                    sr_reg[k+1] <= rem - trial;
                    sq_reg[k+1] <= {sq_reg[k][14:0], 1'b1};
                end
                else
                begin
                    sr_reg[k+1] <= rem;
                    sq_reg[k+1] <= {sq_reg[k][14:0], 1'b0};
                end
                sv_reg[k+1] <= {sv_reg[k][29:0], 2'b00};
                sc_reg[k+1] <= sc_reg[k];
            end
            // radius scale
            rm_reg <= 32'(sc_reg[SqrtSteps].radius) * 32'(sq_reg[SqrtSteps]);
            rc_reg <= sc_reg[SqrtSteps];
            // gain scale
            xm_reg <= 48'((33'(rm_reg) + 33'h8000) >> 16) * 48'(CordicGain);
            xc_reg <= rc_reg;
            // CORDIC rotation stages
            cx_reg[0] <= cw_t'(xm_reg >> 16);
            cy_reg[0] <= '0;
            cz_reg[0] <= 33'(xc_reg.zph);
            cc_reg[0] <= xc_reg;
            for (int k = 0; k < CordicSteps; k++)
            begin
                cw_t dx, dy;
                dx = cy_reg[k] >>> k;
                dy = cx_reg[k] >>> k;
                if (!cz_reg[k][32])
                begin
                    cx_reg[k+1] <= cx_reg[k] - dx;
                    cy_reg[k+1] <= cy_reg[k] + dy;
                    cz_reg[k+1] <= cz_reg[k] - $signed({1'b0, atan_turn(k)});
                end
                else
                begin
                    cx_reg[k+1] <= cx_reg[k] + dx;
                    cy_reg[k+1] <= cy_reg[k] - dy;
                    cz_reg[k+1] <= cz_reg[k] + $signed({1'b0, atan_turn(k)});
                end
                cc_reg[k+1] <= cc_reg[k];
            end
            // round, rotate quadrant, saturate, and zero invalid or single points
            begin
                cw_t rx, ry, px, py;
                rx = (cx_reg[CordicSteps] + 48'sd8192) >>> 14;
                ry = (cy_reg[CordicSteps] + 48'sd8192) >>> 14;
                case (cc_reg[CordicSteps].quad)
                    2'd0: begin px = rx;  py = ry;  end
                    2'd1: begin px = -ry; py = rx;  end
                    2'd2: begin px = -rx; py = -ry; end
                    default: begin px = ry; py = -rx; end
                endcase
                if (px > 48'sd65535) px = 48'sd65535;
                if (px < -48'sd65535) px = -48'sd65535;
                if (py > 48'sd65535) py = 48'sd65535;
                if (py < -48'sd65535) py = -48'sd65535;
                if (!cc_reg[CordicSteps].ok || cc_reg[CordicSteps].single)
                begin
                    px = '0;
                    py = '0;
                end
                ox_reg <= px[16:0];
                oy_reg <= py[16:0];
                ok_reg <= cc_reg[CordicSteps].ok;
            end
        end
    end

    assign out_vld = v_reg[NS];
    assign out_x = ox_reg;
    assign out_y = oy_reg;
    assign out_ok = ok_reg;
endmodule
`default_nettype wire

FILE: design/vdpg_checker.sv
// Port checker for the disk point generator.
`default_nettype none
`include "vogel_disk_point_generator_macros.svh"
module vdpg_checker
    import vdpg_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [16:0] point_x,
    input wire logic signed [16:0] point_y,
    input wire logic               point_valid
);
    logic in_range_x, in_range_y, coords_zero;

    // range and zero tests on the offered point
    assign in_range_x = point_x >= -XyLimit && point_x <= XyLimit;
    assign in_range_y = point_y >= -XyLimit && point_y <= XyLimit;
    assign coords_zero = point_x == 17'sd0 && point_y == 17'sd0;

    `VDPG_NEVER(a_invalid_zero, out_valid && !point_valid && !coords_zero, "invalid point not zero")
    `VDPG_ASSERT(a_x_range, out_valid |-> in_range_x, "x out of range")
    `VDPG_ASSERT(a_y_range, out_valid |-> in_range_y, "y out of range")
    `VDPG_ASSERT(a_ready, !out_valid || out_ready |-> in_ready, "input stalled with free output")
endmodule
bind vogel_disk_point_generator vdpg_checker u_vdpg_checker (.*);
`default_nettype wire

FILE: dv/tb_top.sv
// Testbench for the Vogel disk point generator: directed table, random items, scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module tb_top
    import vdpg_pkg::*;
();

    localparam int DirCount = 20;
    localparam int CycleLimit = 400000;
    localparam int Latency = 74;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = CfgPointCount;
    logic [15:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         point_index = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [16:0] point_x;
    logic signed [16:0] point_y;
    logic               point_valid;

    typedef struct packed {
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic               v;
    } disk_point_t;

    typedef struct {
        logic [7:0]  idx;
        logic        known;
        disk_point_t pt;
    } stim_row_t;

    disk_point_t pending_points[$];
    logic [8:0]  model_count;
    logic [15:0] model_radius;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          recv_hold = 1'b0;
    int          mismatches = 0;
    int          accepted_in = 0;
    int          accepted_out = 0;
    int          cycles = 0;

    vogel_disk_point_generator dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .point_index(point_index), .out_valid(out_valid), .out_ready(out_ready),
        .point_x(point_x), .point_y(point_y), .point_valid(point_valid)
    );

    always #5 clk = ~clk;

    // Floor shift of a signed value
    function automatic longint fshr(input longint v, input int k);
        return v >>> k;
    endfunction

    function automatic logic [31:0] root32(input logic [31:0] val);
        logic [31:0] v;
        logic [31:0] res;
        logic [31:0] bitv;
        v = val;
        res = 0;
        bitv = 32'h40000000;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint clamp_xy(input longint v);
        if (v > 65535) return 65535;
        if (v < -65535) return -65535;
        return v;
    endfunction

    // Compute the expected point for one index
    function automatic disk_point_t disk_point(input logic [7:0] idx);
        disk_point_t p;
        int unsigned cnt;
        logic [63:0] num;
        logic [31:0] ratio;
        logic [31:0] s;
        logic [63:0] r;
        logic [31:0] gf;
        logic [31:0] ang;
        logic [31:0] ph;
        logic [1:0]  quad;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint cx;
        longint cy;
        longint px;
        longint py;
        p = '0;
        cnt = (model_count > MaxPoints) ? MaxPoints : model_count;
        if (cnt == 0 || idx >= cnt) return p;
        p.v = 1'b1;
        if (cnt == 1) return p;
        num = 64'(2 * idx + 1) << 32;
        ratio = 32'(num / 64'(2 * cnt));
        s = root32(ratio);
        r = (64'(model_radius) * 64'(s) + 64'h8000) >> 16;
        gf = 32'((64'd1640531527 + (64'd1 << 15)) >> 16);
        ang = 32'((64'(idx) * 64'(gf)) & 64'hFFFF);
        ph = ang << 16;
        quad = ph[31:30];
        x = longint'((r * 64'd652032874) >> 16);
        y = 0;
        z = longint'(ph & 32'h3FFFFFFF);
        for (int k = 0; k < 20; k++)
        begin
            dx = fshr(y, k);
            dy = fshr(x, k);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(atan_turn(k));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(atan_turn(k));
            end
        end
        cx = fshr(x + 8192, 14);
        cy = fshr(y + 8192, 14);
        case (quad)
            2'd0: begin px = cx;  py = cy;  end
            2'd1: begin px = -cy; py = cx;  end
            2'd2: begin px = -cx; py = -cy; end
            default: begin px = cy; py = -cx; end
        endcase
        p.x = 17'(clamp_xy(px));
        p.y = 17'(clamp_xy(py));
        return p;
    endfunction

    // Cycle counter and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    // Check each accepted point against the oldest expectation
    always @(posedge clk)
    begin
        disk_point_t exp_pt;
        if (rst_n && out_valid && out_ready)
        begin
            accepted_out <= accepted_out + 1;
            if (pending_points.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected point x=%0d y=%0d v=%0b", point_x, point_y,
                             point_valid);
            end
            else
            begin
                exp_pt = pending_points.pop_front();
                if (point_x !== exp_pt.x || point_y !== exp_pt.y
                    || point_valid !== exp_pt.v)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%0d y=%0d v=%0b got x=%0d y=%0d v=%0b",
                                 exp_pt.x, exp_pt.y, exp_pt.v, point_x, point_y,
                                 point_valid);
                end
            end
        end
    end

    // Receiver: random stall, or a long hold-off when asked
    always @(negedge clk)
    begin
        if (!rst_n || recv_hold)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CfgPointCount)
            model_count = val[8:0];
        else
            model_radius = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drop the input, wait for all points, then let the pipe empty
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_points.size() != 0) @(negedge clk);
        repeat (Latency + 8) @(negedge clk);
    endtask

    // Offer one item and hold it until accepted
    task automatic send_item(input logic [7:0] idx, input bit expect_known,
                             input disk_point_t known_pt);
        disk_point_t p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        point_index <= idx;
        p = disk_point(idx);
        if (expect_known && p !== known_pt)
        begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
                $display("table row for index %0d disagrees with prediction", idx);
        end
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_points = {pending_points, (expect_known ? known_pt : p)};
        accepted_in = accepted_in + 1;
        @(negedge clk);
    endtask

    // Random phase: mostly valid indices for the count, some beyond it
    task automatic random_phase(input int n);
        int unsigned lim;
        logic [7:0] idx;
        for (int i = 0; i < n; i++)
        begin
            lim = (model_count > MaxPoints) ? MaxPoints : model_count;
            if (lim != 0 && $urandom_range(9) < 8)
                idx = 8'($urandom_range(lim - 1));
            else
                idx = 8'($urandom);
            send_item(idx, 1'b0, '0);
        end
    endtask

    stim_row_t dir_rows[DirCount];
    disk_point_t zero_pt;

    initial
    begin
        zero_pt = '0;
        model_count = 9'd16;
        model_radius = 16'd256;
        // Directed rows: index, known flag, expected point
        dir_rows[0] = '{8'd16, 1'b1, '{17'sd0, 17'sd0, 1'b0}};
        dir_rows[1] = '{8'd255, 1'b1, '{17'sd0, 17'sd0, 1'b0}};
        for (int i = 2; i < DirCount; i++)
            dir_rows[i] = '{8'(i - 2), 1'b0, zero_pt};
        dir_rows[DirCount - 1].idx = 8'd15;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // After reset: defaults
        foreach (dir_rows[i])
            send_item(dir_rows[i].idx, dir_rows[i].known, dir_rows[i].pt);
        drain();
        // Single point, zero count, oversize count, extreme radius
        write_reg(CfgPointCount, 16'd1);
        send_item(8'd0, 1'b1, '{17'sd0, 17'sd0, 1'b1});
        send_item(8'd1, 1'b1, zero_pt);
        drain();
        write_reg(CfgPointCount, 16'd0);
        send_item(8'd0, 1'b1, zero_pt);
        drain();
        write_reg(CfgPointCount, 16'h01FF);
        write_reg(CfgDiskRadius, 16'hFFFF);
        send_item(8'd0, 1'b0, zero_pt);
        send_item(8'd255, 1'b0, zero_pt);
        drain();

        // Random part: sender light, receiver heavy
        send_idle_pct = 16;
        recv_idle_pct = 82;
        write_reg(CfgPointCount, 16'd256);
        write_reg(CfgDiskRadius, 16'($urandom));
        random_phase(300);
        drain();

        // Sender heavy, receiver light; a small count, then count 256 with random upper bits
        send_idle_pct = 82;
        recv_idle_pct = 16;
        write_reg(CfgPointCount, 16'($urandom_range(2, 40)));
        write_reg(CfgDiskRadius, 16'd0);
        random_phase(150);
        drain();
        write_reg(CfgPointCount, 16'h0100 | 16'($urandom) & 16'hFE00);
        write_reg(CfgDiskRadius, 16'($urandom));
        random_phase(150);
        drain();

        // No idling, with one long receiver hold-off to fill the pipe
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CfgPointCount, 16'($urandom_range(2, 256)));
        write_reg(CfgDiskRadius, 16'hFFFF);
        fork
            begin
                recv_hold = 1'b1;
                repeat (300) @(negedge clk);
                recv_hold = 1'b0;
            end
            random_phase(200);
        join
        drain();
        write_reg(CfgPointCount, 16'($urandom_range(1, 511)));
        write_reg(CfgDiskRadius, 16'($urandom));
        random_phase(200);
        drain();

        $display("covered %0d items in, %0d points out, counts 0..511 and radius extremes",
                 accepted_in, accepted_out);
        if (mismatches == 0 && pending_points.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
